// ----- rtl/whb_pkg.sv -----
// types, constants and state codes shared by the weighted 2d histogram binner
`timescale 1ns / 1ps

package whb_pkg;

  // fixed field widths
  localparam int COORD_W     = 32;
  localparam int WEIGHT_W    = 16;
  localparam int RD_IDX_W    = 6;
  localparam int CUR_W       = 40;
  localparam int BAK_W       = 48;
  localparam int CNT_W       = 32;
  localparam int SINCE_W     = 24;
  localparam int BINS_USED_W = 7;
  localparam int ORIGIN_W    = 32;
  localparam int INV_W       = 32;
  localparam int MUL_W       = 32;

  // offset from origin carries one extra bit, bin product one more
  localparam int OFF_W = ((COORD_W > ORIGIN_W) ? COORD_W : ORIGIN_W) + 1;
  localparam int IP_W  = OFF_W + 1;

  // default grid size
  localparam int X_BINS_DEF = 64;
  localparam int V_BINS_DEF = 64;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_X_ORIGIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_X_INV      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_V_ORIGIN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_V_INV      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_X_BINS     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_V_BINS     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_FLUSH_THR  = 3'd6;

  localparam logic [INV_W-1:0]       INV_RST       = 32'd65536;
  localparam logic [BINS_USED_W-1:0] BINS_USED_RST = 7'd64;
  localparam logic [SINCE_W-1:0]     FLUSH_THR_RST = 24'd1000000;

  // saturation limits
  localparam logic [CUR_W-1:0] CUR_MAX = {1'b0, {(CUR_W-1){1'b1}}};
  localparam logic [CUR_W-1:0] CUR_MIN = {1'b1, {(CUR_W-1){1'b0}}};
  localparam logic [BAK_W-1:0] BAK_MAX = {1'b0, {(BAK_W-1){1'b1}}};
  localparam logic [BAK_W-1:0] BAK_MIN = {1'b1, {(BAK_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

  typedef struct packed {
    logic                       mode;
    logic signed [COORD_W-1:0]  coord_x;
    logic signed [COORD_W-1:0]  coord_v;
    logic signed [WEIGHT_W-1:0] weight;
    logic [RD_IDX_W-1:0]        read_bin_x;
    logic [RD_IDX_W-1:0]        read_bin_v;
  } in_item_t;

  typedef struct packed {
    logic                    in_range;
    logic                    flushed;
    logic signed [BAK_W-1:0] bin_total;
    logic [CNT_W-1:0]        accepted_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OFF,
    S_ABS,
    S_MXL,
    S_MXH,
    S_MVL,
    S_MVH,
    S_VFIN,
    S_RCHK,
    S_ADDR,
    S_RD,
    S_UPD,
    S_FL_RD,
    S_FL_WR,
    S_EMIT
  } fsm_state_t;

endpackage

// ----- rtl/weighted_2d_histogram_binner_unit.sv -----
// top level of the weighted 2d histogram binner: sequencer, bin stores, counters
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_ready  | whb_pkg::in_item_t
//  out_    | out | out_valid / out_ready| whb_pkg::out_item_t
//  cfg_    | in  | cfg_we               | cfg_addr, cfg_wdata
//
// items are taken one at a time: the next is accepted only after the current one is emitted;
// the four partial products of the two bin lookups all go through one 32x32 multiplier
// a deposit that triggers a flush then walks every bin, a read then a write per bin
// after reset both stores are cleared one bin a cycle, with in_ready low
// a waiting result sits in the output register; the next item is still accepted
`timescale 1ns / 1ps

module weighted_2d_histogram_binner_unit #(
  parameter int X_BINS = whb_pkg::X_BINS_DEF,
  parameter int V_BINS = whb_pkg::V_BINS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  whb_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output whb_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [whb_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [whb_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NBINS = X_BINS * V_BINS;
  localparam int AW    = (NBINS > 1) ? $clog2(NBINS) : 1;
  localparam int XI_W  = (X_BINS > 1) ? $clog2(X_BINS) : 1;
  localparam int VI_W  = (V_BINS > 1) ? $clog2(V_BINS) : 1;
  localparam int OFF_W = whb_pkg::OFF_W;
  localparam int IP_W  = whb_pkg::IP_W;
  localparam int MUL_W = whb_pkg::MUL_W;
  localparam int CUR_W = whb_pkg::CUR_W;
  localparam int BAK_W = whb_pkg::BAK_W;

  localparam logic [AW-1:0]   LAST_BIN = AW'(NBINS - 1);
  localparam logic [IP_W-1:0] X_CAP    = IP_W'(X_BINS);
  localparam logic [IP_W-1:0] V_CAP    = IP_W'(V_BINS);
  localparam logic [AW-1:0]   V_STRIDE = AW'(V_BINS);

  // configuration registers
  logic signed [whb_pkg::ORIGIN_W-1:0] x_origin_r, v_origin_r;
  logic [whb_pkg::INV_W-1:0]           x_inv_r, v_inv_r;
  logic [whb_pkg::BINS_USED_W-1:0]     x_bins_used_r, v_bins_used_r;
  logic [whb_pkg::SINCE_W-1:0]         flush_thr_r;

  // control
  whb_pkg::fsm_state_t state_r, state_nxt;
  logic [AW-1:0]       walk_r;
  logic                out_valid_r;

  // counters
  logic [whb_pkg::CNT_W-1:0]   deposit_total_r;
  logic [whb_pkg::SINCE_W-1:0] since_flush_r;

  // per-item datapath registers
  whb_pkg::in_item_t         item_r;
  whb_pkg::out_item_t        out_data_r;
  logic signed [OFF_W-1:0]   off_x_r, off_v_r;
  logic [OFF_W-1:0]          mag_x_r, mag_v_r;
  logic                      neg_x_r, neg_v_r;
  logic [MUL_W-1:0]          plo_hi_r;
  logic                      frac_r;
  logic                      x_ok_r, ok_r, flushed_r;
  logic [XI_W-1:0]           ix_r;
  logic [VI_W-1:0]           iv_r;
  logic [AW-1:0]             addr_r;
  logic [BAK_W-1:0]          total_r;

  // shared multiplier
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;

  // ram ports
  logic             cur_we, cur_re, bak_we, bak_re;
  logic [AW-1:0]    cur_waddr, bak_waddr, rd_addr;
  logic [CUR_W-1:0] cur_wdata, cur_rdata;
  logic [BAK_W-1:0] bak_wdata, bak_rdata;

  // combinational datapath
  logic [IP_W-1:0]         nx, nv, ip;
  logic                    axis_ok;
  logic                    rd_ok;
  logic signed [CUR_W:0]   cur_sum;
  logic [CUR_W-1:0]        cur_sat;
  logic signed [BAK_W:0]   tot_sum;
  logic [BAK_W-1:0]        tot_sat;
  logic [whb_pkg::SINCE_W-1:0] since_inc;
  logic                    flush_hit;
  logic                    in_acc;

  assign in_acc = in_valid && in_ready;

  whb_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p)
  );

  whb_ram #(.WIDTH(CUR_W), .DEPTH(NBINS), .AW(AW)) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (cur_waddr),
    .wdata (cur_wdata),
    .re    (cur_re),
    .raddr (rd_addr),
    .rdata (cur_rdata)
  );

  whb_ram #(.WIDTH(BAK_W), .DEPTH(NBINS), .AW(AW)) u_bak_ram (
    .clk   (clk),
    .we    (bak_we),
    .waddr (bak_waddr),
    .wdata (bak_wdata),
    .re    (bak_re),
    .raddr (rd_addr),
    .rdata (bak_rdata)
  );

  // bins in use, limited to the store size
  assign nx = (IP_W'(x_bins_used_r) < X_CAP) ? IP_W'(x_bins_used_r) : X_CAP;
  assign nv = (IP_W'(v_bins_used_r) < V_CAP) ? IP_W'(v_bins_used_r) : V_CAP;

  // integer part of the bin product: high partial product plus carry-in of the low one
  assign ip = mul_p[IP_W-1:0] + IP_W'(plo_hi_r);

  // below the origin only a zero product still lands in bin 0
  always_comb begin
    if (state_r == whb_pkg::S_MVL) begin
      axis_ok = (!neg_x_r || ((ip == '0) && !frac_r)) && (ip < nx);
    end else begin
      axis_ok = (!neg_v_r || ((ip == '0) && !frac_r)) && (ip < nv);
    end
  end

  assign rd_ok = (IP_W'(item_r.read_bin_x) < nx) && (IP_W'(item_r.read_bin_v) < nv);

  assign cur_sum = $signed({cur_rdata[CUR_W-1], cur_rdata})
                 + $signed({{(CUR_W+1-whb_pkg::WEIGHT_W){item_r.weight[whb_pkg::WEIGHT_W-1]}},
                            item_r.weight});
  assign cur_sat = (cur_sum[CUR_W] != cur_sum[CUR_W-1])
                 ? (cur_sum[CUR_W] ? whb_pkg::CUR_MIN : whb_pkg::CUR_MAX)
                 : cur_sum[CUR_W-1:0];

  assign tot_sum = $signed({{(BAK_W+1-CUR_W){cur_rdata[CUR_W-1]}}, cur_rdata})
                 + $signed({bak_rdata[BAK_W-1], bak_rdata});
  assign tot_sat = (tot_sum[BAK_W] != tot_sum[BAK_W-1])
                 ? (tot_sum[BAK_W] ? whb_pkg::BAK_MIN : whb_pkg::BAK_MAX)
                 : tot_sum[BAK_W-1:0];

  assign since_inc = (since_flush_r != whb_pkg::SINCE_MAX) ? since_flush_r + 1'b1
                                                          : since_flush_r;
  assign flush_hit = (since_inc >= flush_thr_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      whb_pkg::S_CLEAR: begin
        if (walk_r == LAST_BIN) begin
          state_nxt = whb_pkg::S_IDLE;
        end
      end
      whb_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_data.mode ? whb_pkg::S_RCHK : whb_pkg::S_OFF;
        end
      end
      whb_pkg::S_OFF:  state_nxt = whb_pkg::S_ABS;
      whb_pkg::S_ABS:  state_nxt = whb_pkg::S_MXL;
      whb_pkg::S_MXL:  state_nxt = whb_pkg::S_MXH;
      whb_pkg::S_MXH:  state_nxt = whb_pkg::S_MVL;
      whb_pkg::S_MVL:  state_nxt = whb_pkg::S_MVH;
      whb_pkg::S_MVH:  state_nxt = whb_pkg::S_VFIN;
      whb_pkg::S_VFIN: begin
        state_nxt = (x_ok_r && axis_ok) ? whb_pkg::S_ADDR : whb_pkg::S_EMIT;
      end
      whb_pkg::S_RCHK: begin
        state_nxt = rd_ok ? whb_pkg::S_ADDR : whb_pkg::S_EMIT;
      end
      whb_pkg::S_ADDR: state_nxt = whb_pkg::S_RD;
      whb_pkg::S_RD:   state_nxt = whb_pkg::S_UPD;
      whb_pkg::S_UPD: begin
        state_nxt = (!item_r.mode && flush_hit) ? whb_pkg::S_FL_RD : whb_pkg::S_EMIT;
      end
      whb_pkg::S_FL_RD: state_nxt = whb_pkg::S_FL_WR;
      whb_pkg::S_FL_WR: begin
        state_nxt = (walk_r == LAST_BIN) ? whb_pkg::S_EMIT : whb_pkg::S_FL_RD;
      end
      whb_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = whb_pkg::S_IDLE;
        end
      end
      default: state_nxt = whb_pkg::S_IDLE;
    endcase
  end

  // state outputs: in_ready, multiplier operands, ram strobes, addresses and write data
  always_comb begin
    in_ready  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cur_we    = 1'b0;
    bak_we    = 1'b0;
    cur_re    = 1'b0;
    bak_re    = 1'b0;
    cur_waddr = walk_r;
    bak_waddr = walk_r;
    cur_wdata = '0;
    bak_wdata = '0;
    rd_addr   = addr_r;
    case (state_r)
      whb_pkg::S_CLEAR: begin
        cur_we = 1'b1;
        bak_we = 1'b1;
      end
      whb_pkg::S_IDLE: in_ready = 1'b1;
      whb_pkg::S_MXL: begin
        mul_a = mag_x_r[MUL_W-1:0];
        mul_b = x_inv_r;
      end
      whb_pkg::S_MXH: begin
        mul_a = MUL_W'(mag_x_r[OFF_W-1:MUL_W]);
        mul_b = x_inv_r;
      end
      whb_pkg::S_MVL: begin
        mul_a = mag_v_r[MUL_W-1:0];
        mul_b = v_inv_r;
      end
      whb_pkg::S_MVH: begin
        mul_a = MUL_W'(mag_v_r[OFF_W-1:MUL_W]);
        mul_b = v_inv_r;
      end
      whb_pkg::S_RD: begin
        cur_re = 1'b1;
        bak_re = 1'b1;
      end
      whb_pkg::S_UPD: begin
        if (!item_r.mode) begin
          cur_we    = 1'b1;
          cur_waddr = addr_r;
          cur_wdata = cur_sat;
        end
      end
      whb_pkg::S_FL_RD: begin
        cur_re  = 1'b1;
        bak_re  = 1'b1;
        rd_addr = walk_r;
      end
      whb_pkg::S_FL_WR: begin
        cur_we    = 1'b1;
        bak_we    = 1'b1;
        bak_wdata = tot_sat;
      end
      default: begin
      end
    endcase
  end

  // control registers, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= whb_pkg::S_CLEAR;
      walk_r          <= '0;
      out_valid_r     <= 1'b0;
      deposit_total_r <= '0;
      since_flush_r   <= '0;
      x_origin_r      <= '0;
      v_origin_r      <= '0;
      x_inv_r         <= whb_pkg::INV_RST;
      v_inv_r         <= whb_pkg::INV_RST;
      x_bins_used_r   <= whb_pkg::BINS_USED_RST;
      v_bins_used_r   <= whb_pkg::BINS_USED_RST;
      flush_thr_r     <= whb_pkg::FLUSH_THR_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          whb_pkg::CFG_X_ORIGIN:  x_origin_r    <= cfg_wdata[whb_pkg::ORIGIN_W-1:0];
          whb_pkg::CFG_X_INV:     x_inv_r       <= cfg_wdata[whb_pkg::INV_W-1:0];
          whb_pkg::CFG_V_ORIGIN:  v_origin_r    <= cfg_wdata[whb_pkg::ORIGIN_W-1:0];
          whb_pkg::CFG_V_INV:     v_inv_r       <= cfg_wdata[whb_pkg::INV_W-1:0];
          whb_pkg::CFG_X_BINS:    x_bins_used_r <= cfg_wdata[whb_pkg::BINS_USED_W-1:0];
          whb_pkg::CFG_V_BINS:    v_bins_used_r <= cfg_wdata[whb_pkg::BINS_USED_W-1:0];
          whb_pkg::CFG_FLUSH_THR: flush_thr_r   <= cfg_wdata[whb_pkg::SINCE_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_r)
        whb_pkg::S_CLEAR: walk_r <= walk_r + 1'b1;
        whb_pkg::S_UPD: begin
          walk_r <= '0;
          if (!item_r.mode) begin
            if (deposit_total_r != whb_pkg::CNT_MAX) begin
              deposit_total_r <= deposit_total_r + 1'b1;
            end
            since_flush_r <= flush_hit ? '0 : since_inc;
          end
        end
        whb_pkg::S_FL_WR: walk_r <= walk_r + 1'b1;
        default: begin
        end
      endcase

      if (state_r == whb_pkg::S_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state_r)
      whb_pkg::S_IDLE: begin
        if (in_acc) begin
          item_r    <= in_data;
          ok_r      <= 1'b0;
          flushed_r <= 1'b0;
          total_r   <= '0;
        end
      end
      whb_pkg::S_OFF: begin
        off_x_r <= $signed({{(OFF_W-whb_pkg::COORD_W){item_r.coord_x[whb_pkg::COORD_W-1]}},
                            item_r.coord_x})
                 - $signed({{(OFF_W-whb_pkg::ORIGIN_W){x_origin_r[whb_pkg::ORIGIN_W-1]}},
                            x_origin_r});
        off_v_r <= $signed({{(OFF_W-whb_pkg::COORD_W){item_r.coord_v[whb_pkg::COORD_W-1]}},
                            item_r.coord_v})
                 - $signed({{(OFF_W-whb_pkg::ORIGIN_W){v_origin_r[whb_pkg::ORIGIN_W-1]}},
                            v_origin_r});
      end
      whb_pkg::S_ABS: begin
        neg_x_r <= off_x_r[OFF_W-1];
        neg_v_r <= off_v_r[OFF_W-1];
        mag_x_r <= off_x_r[OFF_W-1] ? OFF_W'(-off_x_r) : off_x_r;
        mag_v_r <= off_v_r[OFF_W-1] ? OFF_W'(-off_v_r) : off_v_r;
      end
      whb_pkg::S_MXH, whb_pkg::S_MVH: begin
        // product of the low half: carry part and fraction
        plo_hi_r <= mul_p[2*MUL_W-1:MUL_W];
        frac_r   <= (mul_p[MUL_W-1:0] != '0);
      end
      whb_pkg::S_MVL: begin
        x_ok_r <= axis_ok;
        ix_r   <= ip[XI_W-1:0];
      end
      whb_pkg::S_VFIN: begin
        ok_r <= x_ok_r && axis_ok;
        iv_r <= ip[VI_W-1:0];
      end
      whb_pkg::S_RCHK: begin
        ok_r <= rd_ok;
        ix_r <= XI_W'(item_r.read_bin_x);
        iv_r <= VI_W'(item_r.read_bin_v);
      end
      whb_pkg::S_ADDR: begin
        addr_r <= AW'(ix_r) * V_STRIDE + AW'(iv_r);
      end
      whb_pkg::S_UPD: begin
        if (item_r.mode) begin
          total_r <= tot_sat;
        end else begin
          flushed_r <= flush_hit;
        end
      end
      default: begin
      end
    endcase

    if (state_r == whb_pkg::S_EMIT && (!out_valid_r || out_ready)) begin
      out_data_r.in_range       <= ok_r;
      out_data_r.flushed        <= flushed_r;
      out_data_r.bin_total      <= total_r;
      out_data_r.accepted_count <= deposit_total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a flush is only reported for a deposit that landed in the grid
  a_flush_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.flushed) |-> out_data.in_range)
    else $error("flushed result without in_range");

  // the deposit count never goes down
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != whb_pkg::S_CLEAR) |=> (deposit_total_r >= $past(deposit_total_r)))
    else $error("deposit count decreased");

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accept");

  // the stores are never written while a result is being handed out
  a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == whb_pkg::S_EMIT) |-> (!cur_we && !bak_we))
    else $error("store write during result hand-off");

endmodule

// ----- rtl/whb_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module whb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/whb_mul.sv -----
// shared 32x32 unsigned multiplier with registered product
`timescale 1ns / 1ps

module whb_mul (
  input  logic                          clk,
  input  logic [whb_pkg::MUL_W-1:0]     a,
  input  logic [whb_pkg::MUL_W-1:0]     b,
  output logic [2*whb_pkg::MUL_W-1:0]   prod
);

  logic [2*whb_pkg::MUL_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule
